FILE: src/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/wma_pkg.sv
// Shared types and constants of the windowed moving average.
package wma_pkg;

    localparam int SAMPLE_W  = 16;  // width of a sample and of an average
    localparam int WIN_W     = 6;   // width of the window register
    localparam int SUM_W     = 22;  // signed sum of up to 63 samples
    localparam int MAG_W     = 21;  // magnitude of that sum
    localparam int DIV_CNT_W = 5;   // counts the MAG_W divider steps

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // store the accepted sample and open a new sum
        logic sum_step;   // issue the next history read
        logic div_start;  // load the divider from the finished sum
        logic div_step;   // one restoring-division step
        logic load_out;   // move the quotient into the output register
    } wma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic out_free;
    } wma_status_t;

endpackage

FILE: src/wma_sample_if.sv
// Valid/ready channel that carries input samples.
interface wma_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [wma_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: src/wma_average_if.sv
// Valid/ready channel that carries the computed averages.
interface wma_average_if;
    logic                               valid;
    logic                               ready;
    logic signed [wma_pkg::SAMPLE_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

FILE: src/windowed_moving_average.sv
// Top level of the windowed moving average.
//
//  Channel      Direction  Payload                 Handshake
//  sample_ch    in         sample  (signed 16)     valid / ready
//  average_ch   out        average (signed 16)     valid / ready
//  cfg          in         cfg_wdata (6 bits)      cfg_we, no wait
//
// The sample is written into the history RAM at the edge that accepts it. Its
// average is then formed in order: the newest W entries, W being the window
// clamped to 1..HISTORY_DEPTH, are read and added through the single read port
// of the history RAM; the bit-serial restoring divider loads, runs 21 steps and
// sees that it has ended; and the quotient is loaded into the output register.
// The controller then returns to idle, and no new sample is accepted until the
// previous one has been through every step up to the output load.
// The next item is accepted while the previous average still waits in the
// output register; only the load of a new average stalls on the consumer.
// Reset is asynchronous and active low. The history is treated as all zeros
// after reset through a fill count, so there is no clearing pass.

module windowed_moving_average #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wma_pkg::WIN_W-1:0]    cfg_wdata,
    wma_sample_if.sink                   sample_ch,
    wma_average_if.source                average_ch
);

    // Commands and status between the controller and the datapath.
    wma_pkg::wma_cmd_t    cmd;
    wma_pkg::wma_status_t status;

    // The controller accepts a sample only when it is idle; each accepted
    // item then runs through the store, sum, divide and output steps.
    wma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ch.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the window register, the history memory, the
    // accumulator, the divider and the output register that drives the
    // result channel directly.
    wma_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .sample        (sample_ch.sample),
        .cmd           (cmd),
        .status        (status),
        .average_valid (average_ch.valid),
        .average_ready (average_ch.ready),
        .average       (average_ch.average)
    );

endmodule

FILE: src/wma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/wma_ctrl.sv
// Controller state machine that sequences store, sum, divide and output.
`include "assert_macros.svh"

module wma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  wma_pkg::wma_status_t status,
    output wma_pkg::wma_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        sample_ready = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (status.sum_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPLIES(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")
    `ASSERT_IMPLIES(a_load_when_free, cmd.load_out, status.out_free, "output overwritten")

endmodule

FILE: src/wma_datapath.sv
// Datapath: history RAM, serial accumulator, restoring divider, output register.
`include "assert_macros.svh"

module wma_datapath #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wma_pkg::WIN_W-1:0]            cfg_wdata,
    input  logic signed [wma_pkg::SAMPLE_W-1:0]  sample,
    input  wma_pkg::wma_cmd_t                    cmd,
    output wma_pkg::wma_status_t                 status,
    output logic                                 average_valid,
    input  logic                                 average_ready,
    output logic signed [wma_pkg::SAMPLE_W-1:0]  average
);

    localparam int WIN_W  = wma_pkg::WIN_W;
    localparam int SUM_W  = wma_pkg::SUM_W;
    localparam int MAG_W  = wma_pkg::MAG_W;
    localparam int SMP_W  = wma_pkg::SAMPLE_W;
    localparam int DCW    = wma_pkg::DIV_CNT_W;
    localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    // Configuration and history bookkeeping.
    logic [WIN_W-1:0] window_reg;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [WIN_W-1:0] win_eff;

    // Accumulation.
    logic [AW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [WIN_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    issuing_reg, issuing_next;
    logic                    pend_reg, pend_next;
    logic                    pend_zero_reg, pend_zero_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [SMP_W-1:0]        ram_rdata;

    // Division.
    logic [WIN_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic             neg_reg, neg_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic [SUM_W-1:0] acc_mag;
    logic [WIN_W:0]   shifted;
    logic [WIN_W+1:0] diff;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic signed [SMP_W-1:0] out_data_reg, out_data_next;
    logic [SMP_W-1:0]        quo_low;

    wma_ram #(
        .WIDTH (SMP_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (cmd.start),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Window clamped to 1..HISTORY_DEPTH.
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (CMP_W'(window_reg) > CMP_W'(HISTORY_DEPTH))
        begin
            win_eff = WIN_W'(HISTORY_DEPTH);
        end
        else
        begin
            win_eff = window_reg;
        end
    end

    // Store and accumulate. Entries beyond the fill count were never written
    // and stand for the zeros of the cleared history.
    always_comb
    begin
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_idx_next    = rd_idx_reg;
        issuing_next   = issuing_reg;
        pend_next      = 1'b0;
        pend_zero_next = pend_zero_reg;
        acc_next       = acc_reg;

        if (pend_reg && !pend_zero_reg)
        begin
            acc_next = acc_reg + SUM_W'($signed(ram_rdata));
        end

        if (cmd.start)
        begin
            wp_next      = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            fill_next    = (fill_reg == CNT_W'(HISTORY_DEPTH)) ? fill_reg : fill_reg + 1'b1;
            rd_ptr_next  = wp_reg;
            rd_idx_next  = '0;
            issuing_next = 1'b1;
            acc_next     = '0;
        end
        else if (cmd.sum_step && issuing_reg)
        begin
            rd_ptr_next    = (rd_ptr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_reg - 1'b1;
            rd_idx_next    = rd_idx_reg + 1'b1;
            pend_next      = 1'b1;
            pend_zero_next = !(CMP_W'(rd_idx_reg) < CMP_W'(fill_reg));
            if (rd_idx_reg == win_eff - 1'b1)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    // Restoring division of the sum magnitude by the window, one bit a step.
    assign acc_mag = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, win_eff};

    always_comb
    begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start)
        begin
            rem_next     = '0;
            quo_next     = acc_mag[MAG_W-1:0];
            neg_next     = acc_reg[SUM_W-1];
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
            if (!diff[WIN_W+1])
            begin
                rem_next = diff[WIN_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIN_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    // The quotient magnitude never exceeds 32768, so its low bits suffice.
    assign quo_low = quo_reg[SMP_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = neg_reg ? $signed(-quo_low) : $signed(quo_low);
        end
        else if (average_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= wma_pkg::WINDOW_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        rd_idx_reg    <= rd_idx_next;
        pend_zero_reg <= pend_zero_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        out_data_reg  <= out_data_next;
    end

    assign status.sum_done = !issuing_reg && !pend_reg;
    assign status.div_done = (div_cnt_reg == DCW'(MAG_W));
    assign status.out_free = !out_valid_reg || average_ready;

    assign average_valid = out_valid_reg;
    assign average       = out_data_reg;

    `ASSERT_IMPLIES(a_div_after_sum, cmd.div_start, status.sum_done, "divide before sum ends")
    `ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_reg <= CNT_W'(HISTORY_DEPTH), "fill count overflow")

endmodule
